@@ design/w2s_pkg.sv @@
`default_nettype none
package w2s_pkg;

  // Fixed-point format of coordinates, coefficients and results
  localparam int FRAC_BITS = 16;
  localparam int CW = 32;

  // Product after the fraction shift, row sum, magnitude
  localparam int PW = 2 * CW - FRAC_BITS;
  localparam int RW = PW + 2;
  localparam int MW = RW - 1;

  // Viewport size width
  localparam int SW = 14;

  // Divider: numerator bits (one per step), kept quotient bits;
  // a quotient of 2^QW or more is clamped to 2^QW
  localparam int NW = MW + SW + FRAC_BITS - 1;
  localparam int QW = 41;

  // Final sum width, wide enough for center plus capped ratio
  localparam int SUMW = QW + 3;

  // Smallest depth that counts as in front: 100*w >= 2^FRAC_BITS
  localparam int W_MIN = (2 ** FRAC_BITS + 99) / 100;

  // Configuration port
  localparam int IDXW = 4;
  localparam int DATAW = 64;

  typedef enum logic [IDXW-1:0] {
    REG_ROW0_01,
    REG_ROW0_23,
    REG_ROW1_01,
    REG_ROW1_23,
    REG_ROW2_01,
    REG_ROW2_23,
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_e;

  // One matrix row: coefficients 0..2 and the translation in 3
  typedef logic [3:0][CW-1:0] coef_row_t;
  typedef coef_row_t [2:0] coef_mat_t;

  typedef struct packed {
    logic in_front;
    logic neg;
  } div_tag_t;

  typedef struct packed {
    logic          in_front;
    logic [CW-1:0] sy;
    logic [CW-1:0] sx;
  } result_t;

  // Clamp to the signed 32-bit range
  function automatic logic [CW-1:0] sat32(logic [SUMW-1:0] v);
    logic [CW-1:0] r;
    if ((&v[SUMW-1:CW-1]) || !(|v[SUMW-1:CW-1])) begin
      r = v[CW-1:0];
    end else if (v[SUMW-1]) begin
      r = {1'b1, {(CW-1){1'b0}}};
    end else begin
      r = {1'b0, {(CW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/w2s_row_mac.sv @@
`default_nettype none
module w2s_row_mac
  import w2s_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [CW-1:0]        px,
  input  wire logic [CW-1:0]        py,
  input  wire logic [CW-1:0]        pz,
  input  wire coef_mat_t            coef,
  output logic                      out_valid,
  output logic signed [RW-1:0]      cx,
  output logic signed [RW-1:0]      cy,
  output logic signed [RW-1:0]      cw
);

  logic [CW-1:0]          pt [3];
  logic signed [2*CW-1:0] prod [3][3];
  logic [PW-1:0]          pa [3][3];
  logic                   a_valid;
  logic signed [RW-1:0]   sum [3];

  assign pt[0] = px;
  assign pt[1] = py;
  assign pt[2] = pz;

  // Nine products; the floor shift is the upper part-select
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod[r][k] = signed'(coef[r][k]) * signed'(pt[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          pa[r][k] <= prod[r][k][2*CW-1:FRAC_BITS];
        end
      end
    end
  end

  // Row sums with the translation
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        sum[r] <= {{(RW-PW){pa[r][0][PW-1]}}, pa[r][0]}
                + {{(RW-PW){pa[r][1][PW-1]}}, pa[r][1]}
                + {{(RW-PW){pa[r][2][PW-1]}}, pa[r][2]}
                + {{(RW-CW){coef[r][3][CW-1]}}, coef[r][3]};
      end
    end
  end

  assign cx = sum[0];
  assign cy = sum[1];
  assign cw = sum[2];

endmodule
`default_nettype wire

@@ design/w2s_div_lane.sv @@
`default_nettype none
module w2s_div_lane
  import w2s_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [MW-1:0] in_den,
  input  wire div_tag_t      in_tag,
  output logic               out_valid,
  output logic [QW-1:0]      out_q,
  output logic               out_ovf,
  output logic               out_rem_nz,
  output div_tag_t           out_tag
);

  // Registered outputs of each restoring step
  logic          valid [NW];
  logic [NW-1:0] num   [NW];
  logic [MW-1:0] den   [NW];
  logic [MW-1:0] rem   [NW];
  logic [QW-1:0] q     [NW];
  logic          ovf   [NW];
  div_tag_t      tag   [NW];

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic          s_valid;
    logic [NW-1:0] s_num;
    logic [MW-1:0] s_den;
    logic [MW-1:0] s_rem;
    logic [QW-1:0] s_q;
    logic          s_ovf;
    div_tag_t      s_tag;
    logic [MW:0]   trial;
    logic [MW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign s_valid = in_valid;
      assign s_num = in_num;
      assign s_den = in_den;
      assign s_rem = '0;
      assign s_q = '0;
      assign s_ovf = 1'b0;
      assign s_tag = in_tag;
    end else begin : g_rest
      assign s_valid = valid[i-1];
      assign s_num = num[i-1];
      assign s_den = den[i-1];
      assign s_rem = rem[i-1];
      assign s_q = q[i-1];
      assign s_ovf = ovf[i-1];
      assign s_tag = tag[i-1];
    end

    // One quotient bit per step
    assign trial = {s_rem, s_num[NW-1]};
    assign diff = trial - {1'b0, s_den};
    assign ge = trial >= {1'b0, s_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i] <= 1'b0;
      end else if (en) begin
        valid[i] <= s_valid;
      end
    end

    // Quotient keeps QW bits; a bit shifted out sets the sticky overflow
    always_ff @(posedge clk) begin
      if (en) begin
        num[i] <= {s_num[NW-2:0], 1'b0};
        den[i] <= s_den;
        rem[i] <= ge ? diff[MW-1:0] : trial[MW-1:0];
        q[i] <= {s_q[QW-2:0], ge};
        ovf[i] <= s_ovf | s_q[QW-1];
        tag[i] <= s_tag;
      end
    end
  end

  assign out_valid = valid[NW-1];
  assign out_q = q[NW-1];
  assign out_ovf = ovf[NW-1];
  assign out_rem_nz = |rem[NW-1];
  assign out_tag = tag[NW-1];

  // Points behind the viewer enter with a zero numerator
  a_behind_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_tag.in_front |-> out_q == '0 && !out_ovf && !out_rem_nz)
    else $error("behind point left a nonzero quotient");

endmodule
`default_nettype wire

@@ design/w2s_out_buf.sv @@
`default_nettype none
module w2s_out_buf
  import w2s_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         push_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop = out_valid & out_ready;
  assign push_ready = !skid_valid;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !out_valid) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid entry filled while output could move");

endmodule
`default_nettype wire

@@ design/world_to_screen_projection_unit.sv @@
`default_nettype none
// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid/s_tready      tdata: point_x, point_y, point_z
// m_        out  m_tvalid/m_tready      tdata: screen_x, screen_y; tuser: in_front
// cfg_      in   cfg_valid/cfg_ready    cfg_index, cfg_data (64 bits)
//
// One item per cycle while s_tready is high. Stages in order: matrix products,
// row sums, scaling, the restoring divider (one quotient bit per stage),
// final add and clamp, output register.
// Reset empties the pipeline and loads the register defaults.
// A stall on m_ holds every stage; the skid entry lets one more item in.
module world_to_screen_projection_unit
  import w2s_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [3*CW-1:0]  s_tdata,   // point_x, point_y, point_z
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [2*CW-1:0]       m_tdata,   // screen_x, screen_y
  output logic                  m_tuser,   // in_front
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDXW-1:0]  cfg_index,
  input  wire logic [DATAW-1:0] cfg_data
);

  localparam logic signed [RW-1:0] WMIN_R = RW'(W_MIN);
  localparam logic [SUMW-1:0] HALF = SUMW'(2 ** (FRAC_BITS - 1));

  coef_mat_t     coef;
  logic [SW-1:0] scr_w;
  logic [SW-1:0] scr_h;
  logic          en;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
      scr_w <= SW'(1920);
      scr_h <= SW'(1080);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_e'(cfg_index))
        REG_ROW0_01: coef[0][1:0] <= cfg_data;
        REG_ROW0_23: coef[0][3:2] <= cfg_data;
        REG_ROW1_01: coef[1][1:0] <= cfg_data;
        REG_ROW1_23: coef[1][3:2] <= cfg_data;
        REG_ROW2_01: coef[2][1:0] <= cfg_data;
        REG_ROW2_23: coef[2][3:2] <= cfg_data;
        REG_WIDTH:   scr_w <= cfg_data[SW-1:0];
        REG_HEIGHT:  scr_h <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = en;

  // Matrix rows
  logic                 b_valid;
  logic signed [RW-1:0] cx, cy, cw;

  w2s_row_mac u_mac (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid && s_tready),
    .px(s_tdata[CW-1:0]), .py(s_tdata[2*CW-1:CW]), .pz(s_tdata[3*CW-1:2*CW]),
    .coef(coef),
    .out_valid(b_valid), .cx(cx), .cy(cy), .cw(cw)
  );

  // Depth test, magnitudes and viewport scaling
  logic                 front;
  logic signed [RW-1:0] ncx, ncy;
  logic [MW-1:0]        mag_x, mag_y;
  logic [MW+SW-1:0]     sc_x, sc_y;

  assign front = cw >= WMIN_R;
  assign ncx = -cx;
  assign ncy = -cy;
  assign mag_x = cx[RW-1] ? ncx[MW-1:0] : cx[MW-1:0];
  assign mag_y = cy[RW-1] ? ncy[MW-1:0] : cy[MW-1:0];
  assign sc_x = (MW+SW)'(mag_x) * (MW+SW)'(scr_w);
  assign sc_y = (MW+SW)'(mag_y) * (MW+SW)'(scr_h);

  logic          c_valid;
  logic [NW-1:0] c_num_x, c_num_y;
  logic [MW-1:0] c_den;
  div_tag_t      c_tag_x, c_tag_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_num_x <= front ? {sc_x, {(FRAC_BITS-1){1'b0}}} : '0;
      c_num_y <= front ? {sc_y, {(FRAC_BITS-1){1'b0}}} : '0;
      c_den <= front ? cw[MW-1:0] : MW'(1);
      c_tag_x <= '{in_front: front, neg: cx[RW-1]};
      c_tag_y <= '{in_front: front, neg: cy[RW-1]};
    end
  end

  // Two divider lanes
  logic          xv, yv;
  logic [QW-1:0] qx, qy;
  logic          ovx, ovy, rnx, rny;
  div_tag_t      tx, ty;

  w2s_div_lane u_div_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(c_valid),
    .in_num(c_num_x), .in_den(c_den), .in_tag(c_tag_x),
    .out_valid(xv), .out_q(qx), .out_ovf(ovx), .out_rem_nz(rnx), .out_tag(tx)
  );

  w2s_div_lane u_div_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(c_valid),
    .in_num(c_num_y), .in_den(c_den), .in_tag(c_tag_y),
    .out_valid(yv), .out_q(qy), .out_ovf(ovy), .out_rem_nz(rny), .out_tag(ty)
  );

  // Signed floor ratio, capped; x adds center, ratio and half, y takes ratio and half from center
  logic [QW:0]     rm_x, rm_y;
  logic [SUMW-1:0] pos_x, pos_y, rat_x, rat_y;
  logic [SUMW-1:0] cen_x, cen_y, sum_x, sum_y;

  assign rm_x = ovx ? {1'b1, {QW{1'b0}}} : {1'b0, qx};
  assign rm_y = ovy ? {1'b1, {QW{1'b0}}} : {1'b0, qy};
  assign pos_x = {{(SUMW-QW-1){1'b0}}, rm_x};
  assign pos_y = {{(SUMW-QW-1){1'b0}}, rm_y};
  assign rat_x = tx.neg ? -(pos_x + SUMW'(rnx)) : pos_x;
  assign rat_y = ty.neg ? -(pos_y + SUMW'(rny)) : pos_y;
  assign cen_x = {{(SUMW-SW+1-FRAC_BITS){1'b0}}, scr_w[SW-1:1], {FRAC_BITS{1'b0}}};
  assign cen_y = {{(SUMW-SW+1-FRAC_BITS){1'b0}}, scr_h[SW-1:1], {FRAC_BITS{1'b0}}};
  assign sum_x = cen_x + rat_x + HALF;
  assign sum_y = cen_y - rat_y - HALF;

  logic    f_valid;
  result_t f_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= xv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_res.in_front <= tx.in_front;
      f_res.sx <= tx.in_front ? sat32(sum_x) : '0;
      f_res.sy <= tx.in_front ? sat32(sum_y) : '0;
    end
  end

  // Output register and skid
  result_t o_res;

  w2s_out_buf u_out (
    .clk(clk), .rst(rst),
    .push(f_valid && en), .push_data(f_res), .push_ready(en),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(o_res)
  );

  assign m_tdata = {o_res.sy, o_res.sx};
  assign m_tuser = o_res.in_front;

  a_lanes_valid: assert property (@(posedge clk) disable iff (rst)
    xv == yv)
    else $error("divider lanes out of step");

  a_lanes_front: assert property (@(posedge clk) disable iff (rst)
    xv |-> tx.in_front == ty.in_front)
    else $error("divider lanes disagree on depth test");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en && f_valid |=> f_valid && $stable(f_res))
    else $error("final stage changed while stalled");

endmodule
`default_nettype wire
